[rtl/tls_certificate_message_parser_unit_macros.svh]
// ---------------------------------------------------------------------------
// tls certificate message parser assertion macros
// shared concurrent assertion forms, clocked on i_clk, off during reset
// ---------------------------------------------------------------------------
`ifndef TLS_CERTIFICATE_MESSAGE_PARSER_UNIT_MACROS_SVH
`define TLS_CERTIFICATE_MESSAGE_PARSER_UNIT_MACROS_SVH

// condition holds at every edge
`define TCMP_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the same edge
`define TCMP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define TCMP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tcmp_pkg.sv]
// ---------------------------------------------------------------------------
// tcmp_pkg
// phase codes, field classes and state types of the certificate parser
// ---------------------------------------------------------------------------
package tcmp_pkg;

    localparam logic [3:0] PH_TYPE      = 4'd0;
    localparam logic [3:0] PH_MSGLEN    = 4'd1;
    localparam logic [3:0] PH_CTXLEN    = 4'd2;
    localparam logic [3:0] PH_CTX       = 4'd3;
    localparam logic [3:0] PH_LISTLEN   = 4'd4;
    localparam logic [3:0] PH_CERTLEN   = 4'd5;
    localparam logic [3:0] PH_CERTDATA  = 4'd6;
    localparam logic [3:0] PH_EXTBLKLEN = 4'd7;
    localparam logic [3:0] PH_EXTTYPE   = 4'd8;
    localparam logic [3:0] PH_EXTLEN    = 4'd9;
    localparam logic [3:0] PH_EXTDATA   = 4'd10;
    localparam logic [3:0] PH_DONE      = 4'd11;

    localparam logic [3:0] CLS_TYPE      = 4'd0;
    localparam logic [3:0] CLS_MSGLEN    = 4'd1;
    localparam logic [3:0] CLS_CTXLEN    = 4'd2;
    localparam logic [3:0] CLS_CTX       = 4'd3;
    localparam logic [3:0] CLS_LISTLEN   = 4'd4;
    localparam logic [3:0] CLS_CERTLEN   = 4'd5;
    localparam logic [3:0] CLS_CERTDATA  = 4'd6;
    localparam logic [3:0] CLS_EXTBLKLEN = 4'd7;
    localparam logic [3:0] CLS_EXTTYPE   = 4'd8;
    localparam logic [3:0] CLS_EXTLEN    = 4'd9;
    localparam logic [3:0] CLS_EXTDATA   = 4'd10;
    localparam logic [3:0] CLS_IGNORED   = 4'd11;

    typedef struct packed {
        logic [3:0]  phase;
        logic [1:0]  len_cnt;
        logic [23:0] len_acc;
        logic [7:0]  ctx_rem;
        logic [23:0] list_rem;
        logic [23:0] cert_rem;
        logic [15:0] blk_rem;
        logic [15:0] ext_rem;
        logic [7:0]  entry_cnt;
        logic        err;
    } t_parse_state;

    typedef struct packed {
        logic [7:0] data;
        logic [3:0] cls;
        logic [7:0] idx;
        logic       last;
        logic       done;
        logic       err;
    } t_beat_result;

    localparam t_parse_state C_STATE_RESET = '{phase: PH_TYPE, default: '0};

endpackage

[rtl/tcmp_step.sv]
// ---------------------------------------------------------------------------
// tcmp_step
// next-state and tagging logic for one message byte
// ---------------------------------------------------------------------------
module tcmp_step import tcmp_pkg::*; (
    input  t_parse_state i_state,
    input  logic [7:0]   i_data,
    input  logic         i_msg_start,
    output t_parse_state o_state,
    output t_beat_result o_result
);

    t_parse_state s;
    t_parse_state n;
    logic [3:0]   cls;
    logic         last;
    logic         done;
    logic         err;
    logic         entry_end;
    logic         list_phase;
    logic [23:0]  acc24;
    logic [15:0]  acc16;
    logic [15:0]  blk_dec;
    logic [15:0]  ext_dec;
    logic [23:0]  cert_dec;
    logic [23:0]  cert_len;
    logic [15:0]  blk_len;
    logic [15:0]  ext_len;

    always_comb begin
        s = i_msg_start ? C_STATE_RESET : i_state;
        n = s;
        cls = CLS_IGNORED;
        last = 1'b0;
        done = 1'b0;
        err = 1'b0;
        entry_end = 1'b0;
        list_phase = (s.phase >= PH_CERTLEN) && (s.phase <= PH_EXTDATA);
        if (list_phase && (s.list_rem != 24'd0)) begin
            n.list_rem = s.list_rem - 24'd1;
        end
        acc24 = {s.len_acc[15:0], i_data};
        acc16 = {s.len_acc[7:0], i_data};
        blk_dec = (s.blk_rem != 16'd0) ? s.blk_rem - 16'd1 : s.blk_rem;
        ext_dec = (s.ext_rem != 16'd0) ? s.ext_rem - 16'd1 : s.ext_rem;
        cert_dec = (s.cert_rem != 24'd0) ? s.cert_rem - 24'd1 : s.cert_rem;
        // clamp lengths to what the enclosing field still holds
        cert_len = (acc24 > n.list_rem) ? n.list_rem : acc24;
        blk_len = ({8'd0, acc16} > n.list_rem) ? n.list_rem[15:0] : acc16;
        ext_len = (acc16 > blk_dec) ? blk_dec : acc16;

        unique case (s.phase)
            PH_TYPE: begin
                cls = CLS_TYPE;
                last = 1'b1;
                n.len_cnt = 2'd0;
                n.phase = PH_MSGLEN;
            end
            PH_MSGLEN: begin
                cls = CLS_MSGLEN;
                if (s.len_cnt >= 2'd2) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.phase = PH_CTXLEN;
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_CTXLEN: begin
                cls = CLS_CTXLEN;
                last = 1'b1;
                n.ctx_rem = i_data;
                n.len_cnt = 2'd0;
                n.len_acc = 24'd0;
                n.phase = (i_data != 8'd0) ? PH_CTX : PH_LISTLEN;
            end
            PH_CTX: begin
                cls = CLS_CTX;
                if (s.ctx_rem <= 8'd1) begin
                    n.ctx_rem = 8'd0;
                    last = 1'b1;
                    n.phase = PH_LISTLEN;
                end else begin
                    n.ctx_rem = s.ctx_rem - 8'd1;
                end
            end
            PH_LISTLEN: begin
                cls = CLS_LISTLEN;
                n.len_acc = acc24;
                if (s.len_cnt >= 2'd2) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.list_rem = acc24;
                    n.len_acc = 24'd0;
                    if (acc24 == 24'd0) begin
                        done = 1'b1;
                        n.phase = PH_DONE;
                    end else begin
                        n.phase = PH_CERTLEN;
                    end
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_CERTLEN: begin
                cls = CLS_CERTLEN;
                n.len_acc = acc24;
                if (s.len_cnt >= 2'd2) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.len_acc = 24'd0;
                    err = (acc24 > n.list_rem);
                    n.cert_rem = cert_len;
                    n.phase = (cert_len != 24'd0) ? PH_CERTDATA : PH_EXTBLKLEN;
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_CERTDATA: begin
                cls = CLS_CERTDATA;
                n.cert_rem = cert_dec;
                if (cert_dec == 24'd0) begin
                    last = 1'b1;
                    n.phase = PH_EXTBLKLEN;
                end
            end
            PH_EXTBLKLEN: begin
                cls = CLS_EXTBLKLEN;
                n.len_acc = {8'd0, acc16};
                if (s.len_cnt >= 2'd1) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.len_acc = 24'd0;
                    err = ({8'd0, acc16} > n.list_rem);
                    n.blk_rem = blk_len;
                    if (blk_len == 16'd0) begin
                        entry_end = 1'b1;
                    end else begin
                        n.phase = PH_EXTTYPE;
                    end
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_EXTTYPE: begin
                cls = CLS_EXTTYPE;
                n.blk_rem = blk_dec;
                if (blk_dec == 16'd0) begin
                    err = 1'b1;
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    entry_end = 1'b1;
                end else if (s.len_cnt >= 2'd1) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.len_acc = 24'd0;
                    n.phase = PH_EXTLEN;
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_EXTLEN: begin
                cls = CLS_EXTLEN;
                n.blk_rem = blk_dec;
                n.len_acc = {8'd0, acc16};
                if (s.len_cnt >= 2'd1) begin
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.len_acc = 24'd0;
                    err = (acc16 > blk_dec);
                    n.ext_rem = ext_len;
                    if (ext_len != 16'd0) begin
                        n.phase = PH_EXTDATA;
                    end else if (blk_dec == 16'd0) begin
                        entry_end = 1'b1;
                    end else begin
                        n.phase = PH_EXTTYPE;
                    end
                end else if (blk_dec == 16'd0) begin
                    err = 1'b1;
                    last = 1'b1;
                    n.len_cnt = 2'd0;
                    n.len_acc = 24'd0;
                    entry_end = 1'b1;
                end else begin
                    n.len_cnt = s.len_cnt + 2'd1;
                end
            end
            PH_EXTDATA: begin
                cls = CLS_EXTDATA;
                n.blk_rem = blk_dec;
                n.ext_rem = ext_dec;
                if (ext_dec == 16'd0) begin
                    last = 1'b1;
                    if (blk_dec == 16'd0) begin
                        entry_end = 1'b1;
                    end else begin
                        n.phase = PH_EXTTYPE;
                    end
                end
            end
            default: begin
                // message over: anything more is stray
                cls = CLS_IGNORED;
                err = 1'b1;
                n.phase = PH_DONE;
            end
        endcase

        if (entry_end) begin
            if (s.entry_cnt != 8'hFF) begin
                n.entry_cnt = s.entry_cnt + 8'd1;
            end
            n.phase = PH_CERTLEN;
            n.len_cnt = 2'd0;
            n.len_acc = 24'd0;
        end
        // list used up ends the message, cleanly only at an entry boundary
        if (list_phase && (n.list_rem == 24'd0)) begin
            if (!entry_end) begin
                err = 1'b1;
            end
            last = 1'b1;
            done = 1'b1;
            n.phase = PH_DONE;
            n.len_cnt = 2'd0;
            n.len_acc = 24'd0;
        end
        n.err = s.err | err;

        o_state = n;
        o_result.data = i_data;
        o_result.cls = cls;
        o_result.idx = s.entry_cnt;
        o_result.last = last;
        o_result.done = done;
        o_result.err = n.err;
    end

endmodule

[rtl/tls_certificate_message_parser_unit.sv]
// The parser takes one byte of a TLS 1.3 Certificate message per beat and
// hands back the same byte tagged with its field class, entry number,
// end-of-field and end-of-list marks and the sticky error of the message.
// It accepts one byte every clock; each result appears in the cycle after its
// byte is taken, from an output register, and the input keeps flowing while
// that register is taken in the same cycle. The pace is set by the parse
// state update, which handles one byte per cycle. Raise tuser with the first
// byte of every message to restart the parse.
`include "tls_certificate_message_parser_unit_macros.svh"

// ---------------------------------------------------------------------------
// tls_certificate_message_parser_unit
// byte-wise certificate message walker with registered tagged output
// ---------------------------------------------------------------------------
module tls_certificate_message_parser_unit import tcmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tuser,   // [0] msg_start
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] byte_out, [15:8] entry_index,
                                          // [16] parse_error, [23:17] zero
    output logic [4:0]  o_m_axis_tuser,   // [3:0] field_class, [4] field_last
    output logic        o_m_axis_tlast    // message_done
);

    t_parse_state r_state;
    t_parse_state n_state;
    t_beat_result n_result;
    t_beat_result r_result;
    logic         r_out_valid;
    logic         w_in_beat;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_beat = i_s_axis_tvalid && o_s_axis_tready;

    tcmp_step u_step (
        .i_state     (r_state),
        .i_data      (i_s_axis_tdata),
        .i_msg_start (i_s_axis_tuser),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_STATE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_beat) begin
                r_state <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_beat) begin
            r_result <= n_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata = {7'd0, r_result.err, r_result.idx, r_result.data};
    assign o_m_axis_tuser = {r_result.last, r_result.cls};
    assign o_m_axis_tlast = r_result.done;

    `TCMP_ASSERT_NEXT(a_beat_gives_result, w_in_beat, o_m_axis_tvalid, "accepted byte gave no result")
    `TCMP_ASSERT_SAME(a_done_is_last, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tuser[4], "list end without field end")
    `TCMP_ASSERT_SAME(a_stray_flagged, o_m_axis_tvalid && (o_m_axis_tuser[3:0] == CLS_IGNORED), o_m_axis_tdata[16] && !o_m_axis_tuser[4], "stray byte not flagged")
    `TCMP_ASSERT_ALWAYS(a_list_live, !((r_state.phase >= PH_CERTLEN) && (r_state.phase <= PH_EXTDATA)) || (r_state.list_rem != 24'd0), "list phase with empty list")

endmodule

[test/tls_certificate_message_parser_unit_tb.sv]
// ---------------------------------------------------------------------------
// tls_certificate_message_parser_unit_tb
// streams certificate messages byte by byte into the parser, tags every byte
// with a local model of the field walk and checks each output beat against it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tls_certificate_message_parser_unit_tb;
    import tcmp_pkg::*;

    typedef struct packed {
        logic [7:0] b;
        logic       start;
    } t_msg_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = '0;
    logic        s_start = 1'b0;
    logic        m_ready = 1'b0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [23:0] o_m_axis_tdata;   // [7:0] byte_out, [15:8] entry_index, [16] parse_error
    logic [4:0]  o_m_axis_tuser;   // [3:0] field_class, [4] field_last
    logic        o_m_axis_tlast;

    tls_certificate_message_parser_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_start),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    t_msg_byte    pending_bytes[$];
    t_beat_result tagged_q[$];
    t_msg_byte    next_byte;
    t_beat_result want;

    int mismatches = 0;
    int beats_in = 0;
    int beats_out = 0;
    int msg_count = 0;
    int list_ends = 0;
    int flagged = 0;
    int src_gap = 0;
    int sink_gap = 0;

    // parse state of the local model
    logic [3:0]  ph;
    logic [1:0]  lcnt;
    logic [23:0] lacc;
    logic [7:0]  ctx_rem;
    logic [23:0] list_rem;
    logic [23:0] cert_rem;
    logic [15:0] blk_rem;
    logic [15:0] ext_rem;
    logic [7:0]  entries;
    logic        err_flag;

    function automatic void clear_parse();
        ph       = PH_TYPE;
        lcnt     = '0;
        lacc     = '0;
        ctx_rem  = '0;
        list_rem = '0;
        cert_rem = '0;
        blk_rem  = '0;
        ext_rem  = '0;
        entries  = '0;
        err_flag = 1'b0;
    endfunction

    function automatic t_beat_result tag_byte(input logic [7:0] b, input logic start);
        t_beat_result r;
        logic [3:0]   cls;
        logic         last;
        logic         done;
        logic         e;
        logic         entry_end;
        logic         in_list;
        if (start) clear_parse();
        cls       = CLS_IGNORED;
        last      = 1'b0;
        done      = 1'b0;
        e         = 1'b0;
        entry_end = 1'b0;
        r.idx     = entries;
        in_list   = (ph >= PH_CERTLEN) && (ph <= PH_EXTDATA);
        // every byte inside the list uses up one list byte
        if (in_list && list_rem != 0) list_rem = list_rem - 24'd1;

        case (ph)
            PH_TYPE: begin
                cls = CLS_TYPE; last = 1'b1; lcnt = '0; ph = PH_MSGLEN;
            end
            PH_MSGLEN: begin
                cls = CLS_MSGLEN;
                if (lcnt >= 2) begin
                    last = 1'b1; lcnt = '0; ph = PH_CTXLEN;
                end else lcnt = lcnt + 2'd1;
            end
            PH_CTXLEN: begin
                cls = CLS_CTXLEN; last = 1'b1; ctx_rem = b; lcnt = '0; lacc = '0;
                ph = (b != 0) ? PH_CTX : PH_LISTLEN;
            end
            PH_CTX: begin
                cls = CLS_CTX;
                if (ctx_rem <= 1) begin
                    ctx_rem = '0; last = 1'b1; ph = PH_LISTLEN;
                end else ctx_rem = ctx_rem - 8'd1;
            end
            PH_LISTLEN: begin
                cls = CLS_LISTLEN;
                lacc = {lacc[15:0], b};
                if (lcnt >= 2) begin
                    last = 1'b1; lcnt = '0; list_rem = lacc; lacc = '0;
                    if (list_rem == 0) begin
                        done = 1'b1; ph = PH_DONE;
                    end else ph = PH_CERTLEN;
                end else lcnt = lcnt + 2'd1;
            end
            PH_CERTLEN: begin
                cls = CLS_CERTLEN;
                lacc = {lacc[15:0], b};
                if (lcnt >= 2) begin
                    last = 1'b1; lcnt = '0; cert_rem = lacc; lacc = '0;
                    if (cert_rem > list_rem) begin
                        e = 1'b1; cert_rem = list_rem;
                    end
                    ph = (cert_rem != 0) ? PH_CERTDATA : PH_EXTBLKLEN;
                end else lcnt = lcnt + 2'd1;
            end
            PH_CERTDATA: begin
                cls = CLS_CERTDATA;
                if (cert_rem != 0) cert_rem = cert_rem - 24'd1;
                if (cert_rem == 0) begin
                    last = 1'b1; ph = PH_EXTBLKLEN;
                end
            end
            PH_EXTBLKLEN: begin
                cls = CLS_EXTBLKLEN;
                lacc = {8'h00, lacc[7:0], b};
                if (lcnt >= 1) begin
                    last = 1'b1; lcnt = '0; blk_rem = lacc[15:0]; lacc = '0;
                    if ({8'h00, blk_rem} > list_rem) begin
                        e = 1'b1; blk_rem = list_rem[15:0];
                    end
                    if (blk_rem == 0) entry_end = 1'b1;
                    else ph = PH_EXTTYPE;
                end else lcnt = lcnt + 2'd1;
            end
            PH_EXTTYPE: begin
                cls = CLS_EXTTYPE;
                if (blk_rem != 0) blk_rem = blk_rem - 16'd1;
                if (blk_rem == 0) begin
                    e = 1'b1; last = 1'b1; lcnt = '0; entry_end = 1'b1;
                end else if (lcnt >= 1) begin
                    last = 1'b1; lcnt = '0; lacc = '0; ph = PH_EXTLEN;
                end else lcnt = lcnt + 2'd1;
            end
            PH_EXTLEN: begin
                cls = CLS_EXTLEN;
                if (blk_rem != 0) blk_rem = blk_rem - 16'd1;
                lacc = {8'h00, lacc[7:0], b};
                if (lcnt >= 1) begin
                    last = 1'b1; lcnt = '0; ext_rem = lacc[15:0]; lacc = '0;
                    if (ext_rem > blk_rem) begin
                        e = 1'b1; ext_rem = blk_rem;
                    end
                    if (ext_rem != 0) ph = PH_EXTDATA;
                    else if (blk_rem == 0) entry_end = 1'b1;
                    else ph = PH_EXTTYPE;
                end else if (blk_rem == 0) begin
                    e = 1'b1; last = 1'b1; lcnt = '0; lacc = '0; entry_end = 1'b1;
                end else lcnt = lcnt + 2'd1;
            end
            PH_EXTDATA: begin
                cls = CLS_EXTDATA;
                if (blk_rem != 0) blk_rem = blk_rem - 16'd1;
                if (ext_rem != 0) ext_rem = ext_rem - 16'd1;
                if (ext_rem == 0) begin
                    last = 1'b1;
                    if (blk_rem == 0) entry_end = 1'b1;
                    else ph = PH_EXTTYPE;
                end
            end
            default: begin
                cls = CLS_IGNORED; e = 1'b1;
            end
        endcase

        if (entry_end) begin
            if (entries != 8'hFF) entries = entries + 8'd1;
            ph = PH_CERTLEN; lcnt = '0; lacc = '0;
        end
        // list used up: anything still open is truncated
        if (in_list && list_rem == 0) begin
            if (!entry_end) e = 1'b1;
            last = 1'b1; done = 1'b1; ph = PH_DONE; lcnt = '0; lacc = '0;
        end
        err_flag = err_flag | e;

        r.data = b;
        r.cls  = cls;
        r.last = last;
        r.done = done;
        r.err  = err_flag;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 50) $display("mismatch at result beat %0d: %s", beats_out, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned exp_v);
        if (got != exp_v) report_mismatch($sformatf("%s got %0d want %0d", name, got, exp_v));
    endtask

    task automatic queue_beat(input logic [7:0] b, input logic start);
        t_msg_byte m;
        m.b     = b;
        m.start = start;
        pending_bytes.push_back(m);
    endtask

    // message with random content, well formed but for a type byte that is sometimes
    // random; damage: 0 none, 1 overwrite a byte, 2 cut short, 3 trailing junk
    task automatic queue_cert_msg(input int ctx_len, input int n_entries, input int max_cert,
                                  input int max_ext, input int damage);
        logic [7:0] lst[$];
        logic [7:0] exts[$];
        logic [7:0] msg[$];
        int         cert_len;
        int         ext_len;
        int         body_len;
        int         cut;
        for (int n = 0; n < n_entries; n++) begin
            exts.delete();
            repeat ($urandom_range(0, max_ext)) begin
                ext_len = $urandom_range(0, 3);
                exts.push_back(8'($urandom));
                exts.push_back(8'($urandom));
                exts.push_back(8'h00);
                exts.push_back(ext_len[7:0]);
                repeat (ext_len) exts.push_back(8'($urandom));
            end
            cert_len = $urandom_range(0, max_cert);
            lst.push_back(cert_len[23:16]);
            lst.push_back(cert_len[15:8]);
            lst.push_back(cert_len[7:0]);
            repeat (cert_len) lst.push_back(8'($urandom));
            lst.push_back(8'(exts.size() >> 8));
            lst.push_back(8'(exts.size()));
            foreach (exts[i]) lst.push_back(exts[i]);
        end
        body_len = 4 + ctx_len + lst.size();
        msg.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h0B);
        msg.push_back(body_len[23:16]);
        msg.push_back(body_len[15:8]);
        msg.push_back(body_len[7:0]);
        msg.push_back(ctx_len[7:0]);
        repeat (ctx_len) msg.push_back(8'($urandom));
        msg.push_back(8'(lst.size() >> 16));
        msg.push_back(8'(lst.size() >> 8));
        msg.push_back(8'(lst.size()));
        foreach (lst[i]) msg.push_back(lst[i]);
        case (damage)
            1: msg[$urandom_range(1, msg.size() - 1)] = 8'($urandom);
            2: begin
                cut = $urandom_range(1, msg.size() - 1);
                while (msg.size() > cut) void'(msg.pop_back());
            end
            3: repeat ($urandom_range(1, 4)) msg.push_back(8'($urandom));
            default: ;
        endcase
        foreach (msg[i]) queue_beat(msg[i], i == 0);
        msg_count++;
    endtask

    // source side: one beat per accepted item, bursts of idle between beats
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_valid && o_s_axis_tready) begin
                tagged_q.push_back(tag_byte(s_data, s_start));
                beats_in++;
            end
            if (!s_valid || o_s_axis_tready) begin
                if (src_gap != 0) begin
                    s_valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_bytes.size() != 0) begin
                    next_byte = pending_bytes.pop_front();
                    s_valid   <= 1'b1;
                    s_data    <= next_byte.b;
                    s_start   <= next_byte.start;
                    if (pending_bytes.size() >= 150 && $urandom_range(0, 7) == 0)
                        src_gap <= $urandom_range(1, 6);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // sink side: compare every result beat with the oldest tagged byte
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready  <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (o_m_axis_tvalid && m_ready) begin
                if (tagged_q.size() == 0) begin
                    report_mismatch("result beat with no byte outstanding");
                end else begin
                    want = tagged_q.pop_front();
                    check_field("byte_out", 32'(o_m_axis_tdata[7:0]), 32'(want.data));
                    check_field("entry_index", 32'(o_m_axis_tdata[15:8]), 32'(want.idx));
                    check_field("parse_error", 32'(o_m_axis_tdata[16]), 32'(want.err));
                    check_field("field_class", 32'(o_m_axis_tuser[3:0]), 32'(want.cls));
                    check_field("field_last", 32'(o_m_axis_tuser[4]), 32'(want.last));
                    check_field("message_done", 32'(o_m_axis_tlast), 32'(want.done));
                    if (want.done) list_ends++;
                    if (want.err) flagged++;
                end
                beats_out++;
            end
            if (sink_gap != 0) begin
                m_ready  <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                m_ready <= 1'b1;
                if (pending_bytes.size() >= 150 && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 6);
            end
        end
    end

    initial begin
        // header only, empty list, all-ones bytes, then a byte past the end
        static logic [7:0] empty_list [8] = '{8'hFF, 8'hFF, 8'hFF, 8'hFF,
                                              8'h00, 8'h00, 8'h00, 8'h00};
        // certificate length beyond the list, list runs out before the entry ends
        static logic [7:0] cert_overrun [13] = '{8'h0B, 8'h00, 8'h00, 8'h09, 8'h00,
                                                 8'h00, 8'h00, 8'h05, 8'h00, 8'h00,
                                                 8'h09, 8'hA5, 8'h5A};
        int kind;
        int dmg;
        int rand_start;
        clear_parse();
        foreach (empty_list[i]) queue_beat(empty_list[i], i == 0);
        queue_beat(8'hFF, 1'b0);
        foreach (cert_overrun[i]) queue_beat(cert_overrun[i], i == 0);
        msg_count = 2;

        rand_start = pending_bytes.size();
        while (pending_bytes.size() - rand_start < 1150) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // noise with random restarts
                repeat ($urandom_range(1, 6))
                    queue_beat(8'($urandom), 1'($urandom_range(0, 1)));
            end else begin
                dmg = (kind <= 3) ? $urandom_range(1, 3) : 0;
                queue_cert_msg(($urandom_range(0, 39) == 0) ? $urandom_range(200, 255)
                                                            : $urandom_range(0, 3),
                               $urandom_range(0, 3), $urandom_range(0, 6),
                               $urandom_range(0, 2), dmg);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_valid || tagged_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (tagged_q.size() != 0) report_mismatch("tagged bytes left without a result");

        $display("covered %0d beats over %0d messages: %0d list ends, %0d beats with error set",
                 beats_out, msg_count, list_ends, flagged);
        if (mismatches == 0) begin
            $display("tls_certificate_message_parser_unit_tb: done, clean");
        end else begin
            $display("tls_certificate_message_parser_unit_tb: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d bytes still pending", pending_bytes.size());
        $display("tls_certificate_message_parser_unit_tb: done, errors");
        $finish;
    end

endmodule
